// ----- src/egub_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the exp-Golomb / unary binarizer.
// Used by egub_ctrl, egub_dp and the top level; depends on nothing.
package egub_pkg;

    localparam int MAX_UNARY_DEF     = 62;
    localparam int CONTEXT_COUNT_DEF = 64;

    // Binarization modes carried on the operation field.
    localparam logic [2:0] OP_UNARY  = 3'd0;
    localparam logic [2:0] OP_SUNARY = 3'd1;
    localparam logic [2:0] OP_TUNARY = 3'd2;
    localparam logic [2:0] OP_EG     = 3'd3;
    localparam logic [2:0] OP_SEG    = 3'd4;
    localparam logic [2:0] OP_EEG    = 3'd5;
    localparam logic [2:0] OP_SEEG   = 3'd6;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_SCAN,
        ST_DISPATCH,
        ST_ZEROS,
        ST_ONE,
        ST_INFO_A,
        ST_INFO_B,
        ST_SIGN
    } state_t;

    // Segment of the bin string being emitted.
    typedef enum logic [2:0] {
        PH_NONE,
        PH_ZEROS,
        PH_ONE,
        PH_INFO_A,
        PH_INFO_B,
        PH_SIGN
    } phase_t;

    typedef struct packed {
        logic   load;
        logic   prep;
        logic   scan;
        logic   pop;
        phase_t phase;
    } cmd_t;

    typedef struct packed {
        logic is_exp;
        logic scan_found;
        logic zeros_left;
        logic zeros_end;
        logic one_left;
        logic a_left;
        logic a_end;
        logic b_left;
        logic b_end;
        logic sign_left;
    } status_t;

endpackage

// ----- src/egub_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer for the binarizer: walks setup, leading-one scan and the bin segments.
// Depends on egub_pkg; drives the datapath egub_dp through cmd_t / status_t.
module egub_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  egub_pkg::status_t status,
    output egub_pkg::cmd_t    cmd
);
    import egub_pkg::*;

    state_t state_reg;
    state_t state_next;
    state_t pick_b;
    state_t pick_a;
    state_t pick_one;
    state_t pick_z;
    state_t pick_all;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // First segment that still holds bins, starting after the named one.
    always_comb
    begin
        pick_b   = status.sign_left  ? ST_SIGN   : ST_IDLE;
        pick_a   = status.b_left     ? ST_INFO_B : pick_b;
        pick_one = status.a_left     ? ST_INFO_A : pick_a;
        pick_z   = status.one_left   ? ST_ONE    : pick_one;
        pick_all = status.zeros_left ? ST_ZEROS  : pick_z;
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        cmd.load   = 1'b0;
        cmd.prep   = 1'b0;
        cmd.scan   = 1'b0;
        cmd.pop    = 1'b0;
        cmd.phase  = PH_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = status.is_exp ? ST_SCAN : ST_DISPATCH;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_found)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                state_next = pick_all;
            end
            ST_ZEROS:
            begin
                cmd.phase = PH_ZEROS;
                out_valid = 1'b1;
                cmd.pop   = out_ready;
                if (out_ready && status.zeros_end)
                begin
                    state_next = pick_z;
                end
            end
            ST_ONE:
            begin
                cmd.phase = PH_ONE;
                out_valid = 1'b1;
                cmd.pop   = out_ready;
                if (out_ready)
                begin
                    state_next = pick_one;
                end
            end
            ST_INFO_A:
            begin
                cmd.phase = PH_INFO_A;
                out_valid = 1'b1;
                cmd.pop   = out_ready;
                if (out_ready && status.a_end)
                begin
                    state_next = pick_a;
                end
            end
            ST_INFO_B:
            begin
                cmd.phase = PH_INFO_B;
                out_valid = 1'b1;
                cmd.pop   = out_ready;
                if (out_ready && status.b_end)
                begin
                    state_next = pick_b;
                end
            end
            ST_SIGN:
            begin
                cmd.phase = PH_SIGN;
                out_valid = 1'b1;
                cmd.pop   = out_ready;
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- src/egub_dp.sv -----
`timescale 1ns / 1ps
// Datapath of the binarizer: magnitude and clamping, byte-wise leading-one scan,
// segment counters and the bin multiplexer. Depends on egub_pkg.
module egub_dp #(
    parameter int MAX_UNARY     = egub_pkg::MAX_UNARY_DEF,
    parameter int CONTEXT_COUNT = egub_pkg::CONTEXT_COUNT_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [2:0]         operation,
    input  logic signed [31:0] value,
    input  logic [5:0]         max_count,
    input  logic [5:0]         context_req,
    input  egub_pkg::cmd_t     cmd,
    output egub_pkg::status_t  status,
    output logic               bin,
    output logic [5:0]         bin_context,
    output logic               last,
    output logic               overflow
);
    import egub_pkg::*;

    function automatic logic [3:0] bit_len(input logic [7:0] v);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < 8; i++)
        begin
            if (v[i])
            begin
                n = 4'(i + 1);
            end
        end
        return n;
    endfunction

    // Payload registers.
    logic [2:0]  op_reg,    op_next;
    logic [31:0] raw_reg,   raw_next;
    logic [5:0]  limit_reg, limit_next;
    logic [5:0]  ctx_reg,   ctx_next;
    logic        ovf_reg,   ovf_next;
    logic [31:0] x_reg,     x_next;
    logic [31:0] aval_reg,  aval_next;

    // Segment counters.
    logic [1:0]  scan_idx_reg, scan_idx_next;
    logic [5:0]  nz_reg,       nz_next;
    logic        one_reg,      one_next;
    logic [4:0]  na_reg,       na_next;
    logic [4:0]  nb_reg,       nb_next;
    logic        sign_reg,     sign_next;

    logic        neg;
    logic        signed_mode;
    logic        unary_op;
    logic        exp_op;
    logic        eeg_op;
    logic        force_zero;
    logic [31:0] max32;
    logic        big;
    logic [5:0]  mag_low;
    logic [5:0]  mag_c;
    logic        trunc_clip;
    logic [5:0]  mag_t;
    logic [31:0] x_val;
    logic [5:0]  ctx_sat;
    logic [7:0]  scan_byte;
    logic        scan_found;
    logic [5:0]  k;
    logic [5:0]  km1;
    logic [3:0]  k2;
    logic [3:0]  k2m1;
    logic [6:0]  total;

    assign neg         = raw_reg[31];
    assign signed_mode = (op_reg == OP_SUNARY) || (op_reg == OP_SEG) || (op_reg == OP_SEEG);
    assign unary_op    = (op_reg == OP_UNARY) || (op_reg == OP_SUNARY)
                         || (op_reg == OP_TUNARY);
    assign eeg_op      = (op_reg == OP_EEG) || (op_reg == OP_SEEG);
    assign exp_op      = (op_reg == OP_EG) || (op_reg == OP_SEG) || eeg_op;
    assign force_zero  = neg && !signed_mode;
    assign max32       = 32'(MAX_UNARY);

    // Unary clamp is decided on the raw word, so no negation sits in front of it.
    assign big        = !force_zero
                        && (neg ? (raw_reg < (32'd0 - max32)) : (raw_reg > max32));
    assign mag_low    = neg ? (~raw_reg[5:0] + 6'd1) : raw_reg[5:0];
    assign mag_c      = force_zero ? 6'd0 : (big ? 6'(MAX_UNARY) : mag_low);
    assign trunc_clip = (op_reg == OP_TUNARY) && (mag_c > limit_reg);
    assign mag_t      = trunc_clip ? limit_reg : mag_c;

    // x = magnitude + 1; for a negative value that is ~raw + 2.
    assign x_val = force_zero ? 32'd1
                              : ((neg ? ~raw_reg : raw_reg) + (neg ? 32'd2 : 32'd1));

    assign ctx_sat = ({3'd0, context_req} >= 9'(CONTEXT_COUNT))
                     ? 6'(CONTEXT_COUNT - 1) : context_req;

    // Leading-one search over x, one byte per cycle from the top.
    assign scan_byte  = x_reg[{scan_idx_reg, 3'b000} +: 8];
    assign scan_found = (scan_byte != 8'd0) || (scan_idx_reg == 2'd0);
    assign k          = {1'b0, scan_idx_reg, 3'b000} + {2'b00, bit_len(scan_byte)};
    assign km1        = k - 6'd1;
    assign k2         = bit_len({2'b00, k});
    assign k2m1       = k2 - 4'd1;

    always_comb
    begin
        op_next       = op_reg;
        raw_next      = raw_reg;
        limit_next    = limit_reg;
        ctx_next      = ctx_reg;
        ovf_next      = ovf_reg;
        x_next        = x_reg;
        aval_next     = aval_reg;
        scan_idx_next = scan_idx_reg;
        nz_next       = nz_reg;
        one_next      = one_reg;
        na_next       = na_reg;
        nb_next       = nb_reg;
        sign_next     = sign_reg;

        if (cmd.load)
        begin
            op_next    = operation;
            raw_next   = $unsigned(value);
            limit_next = max_count;
            ctx_next   = ctx_sat;
        end

        if (cmd.prep)
        begin
            ovf_next      = force_zero || (unary_op && big) || trunc_clip;
            x_next        = x_val;
            scan_idx_next = 2'd3;
            nz_next       = unary_op ? mag_t : 6'd0;
            one_next      = unary_op ? ((op_reg != OP_TUNARY) || (mag_t < limit_reg)) : exp_op;
            na_next       = 5'd0;
            nb_next       = 5'd0;
            sign_next     = signed_mode && (raw_reg != 32'd0);
        end

        if (cmd.scan)
        begin
            if (scan_found)
            begin
                if (eeg_op)
                begin
                    // Exp-Golomb code of k-1 as prefix, then k-1 info bits of x.
                    nz_next   = {2'b00, k2m1};
                    na_next   = {1'b0, k2m1};
                    aval_next = {26'd0, k};
                    nb_next   = km1[4:0];
                end
                else
                begin
                    nz_next   = km1;
                    na_next   = km1[4:0];
                    aval_next = x_reg;
                    nb_next   = 5'd0;
                end
            end
            else
            begin
                scan_idx_next = scan_idx_reg - 2'd1;
            end
        end

        if (cmd.pop)
        begin
            case (cmd.phase)
                PH_ZEROS:  nz_next   = nz_reg - 6'd1;
                PH_ONE:    one_next  = 1'b0;
                PH_INFO_A: na_next   = na_reg - 5'd1;
                PH_INFO_B: nb_next   = nb_reg - 5'd1;
                PH_SIGN:   sign_next = 1'b0;
                default:   nz_next   = nz_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        raw_reg   <= raw_next;
        limit_reg <= limit_next;
        ctx_reg   <= ctx_next;
        ovf_reg   <= ovf_next;
        x_reg     <= x_next;
        aval_reg  <= aval_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg <= 2'd0;
            nz_reg       <= 6'd0;
            one_reg      <= 1'b0;
            na_reg       <= 5'd0;
            nb_reg       <= 5'd0;
            sign_reg     <= 1'b0;
        end
        else
        begin
            scan_idx_reg <= scan_idx_next;
            nz_reg       <= nz_next;
            one_reg      <= one_next;
            na_reg       <= na_next;
            nb_reg       <= nb_next;
            sign_reg     <= sign_next;
        end
    end

    always_comb
    begin
        case (cmd.phase)
            PH_ZEROS:  bin = 1'b0;
            PH_ONE:    bin = 1'b1;
            PH_INFO_A: bin = aval_reg[na_reg - 5'd1];
            PH_INFO_B: bin = x_reg[nb_reg - 5'd1];
            PH_SIGN:   bin = ~raw_reg[31];
            default:   bin = 1'b0;
        endcase
    end

    assign total = {1'b0, nz_reg} + {6'd0, one_reg} + {2'b00, na_reg}
                   + {2'b00, nb_reg} + {6'd0, sign_reg};

    assign last        = (total == 7'd1);
    assign bin_context = ctx_reg;
    assign overflow    = ovf_reg;

    assign status.is_exp     = exp_op;
    assign status.scan_found = scan_found;
    assign status.zeros_left = (nz_reg != 6'd0);
    assign status.zeros_end  = (nz_reg == 6'd1);
    assign status.one_left   = one_reg;
    assign status.a_left     = (na_reg != 5'd0);
    assign status.a_end      = (na_reg == 5'd1);
    assign status.b_left     = (nb_reg != 5'd0);
    assign status.b_end      = (nb_reg == 5'd1);
    assign status.sign_left  = sign_reg;

endmodule

// ----- src/exp_golomb_unary_binarizer.sv -----
`timescale 1ns / 1ps
// Top level of the exp-Golomb / unary binarizer: controller plus datapath.
// Depends on egub_pkg, egub_ctrl and egub_dp.

// The block takes one value with a mode and a context and emits its bin string,
// one bin per output item, each tagged with the (saturated) context, the overflow
// flag and a last marker on the final bin. It works on one item at a time. After
// an item is accepted the controller passes through a setup state, then in the
// exp-Golomb modes a byte-wide leading-one scan of magnitude+1 from the top byte,
// then a dispatch state, then emits one bin per cycle while the output is ready,
// and returns to idle, where the next item is taken. The longest bin string has
// 64 bins (signed exp-Golomb of the largest magnitude, whose scan stops at the
// top byte). A value with no bins (mode 7, or truncated unary with a zero limit)
// produces no output item.
module exp_golomb_unary_binarizer #(
    parameter int MAX_UNARY     = egub_pkg::MAX_UNARY_DEF,
    parameter int CONTEXT_COUNT = egub_pkg::CONTEXT_COUNT_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         operation,
    input  logic signed [31:0] value,
    input  logic [5:0]         max_count,
    input  logic [5:0]         context_req,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               bin,
    output logic [5:0]         bin_context,
    output logic               last,
    output logic               overflow
);
    import egub_pkg::*;

    cmd_t    cmd;
    status_t status;

    egub_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    egub_dp #(
        .MAX_UNARY     (MAX_UNARY),
        .CONTEXT_COUNT (CONTEXT_COUNT)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .operation   (operation),
        .value       (value),
        .max_count   (max_count),
        .context_req (context_req),
        .cmd         (cmd),
        .status      (status),
        .bin         (bin),
        .bin_context (bin_context),
        .last        (last),
        .overflow    (overflow)
    );

`ifndef SYNTHESIS
    // Input and output sides are never open in the same cycle.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while a bin is pending");

    // Setup always follows an accepted item.
    a_setup_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (!out_valid && !in_ready))
        else $error("no setup cycle after an accepted item");

    // Nothing more is emitted after the last bin of an item.
    a_quiet_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last) |=> !out_valid)
        else $error("bin emitted after the last bin");

    // Context and overflow stay fixed across the bins of one item.
    a_tags_steady: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last) |=> ($stable(overflow) && $stable(bin_context)))
        else $error("item tags changed within one bin string");
`endif

endmodule
